/* hw/rtl/message_fifo_with_type_purge_defines.svh */
// assertion macros shared by the message fifo modules
// MFQ_ASSERT checks that a property holds, MFQ_NEVER that a condition never occurs
`ifndef MESSAGE_FIFO_WITH_TYPE_PURGE_DEFINES_SVH
`define MESSAGE_FIFO_WITH_TYPE_PURGE_DEFINES_SVH
`ifndef SYNTHESIS
`define MFQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MFQ_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MFQ_ASSERT(label, clk, rst_n, prop, msg)
`define MFQ_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* hw/rtl/mfq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mfq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 64;
    localparam int WORD_W = 32;
    localparam int CMD_W = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_FLUSH_CODE = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT    = 3'd0,
        CMD_GET    = 3'd1,
        CMD_FLUSH  = 3'd2,
        CMD_ABORT  = 3'd3,
        CMD_START  = 3'd4,
        CMD_REMOVE = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_ABORTED = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET_WAIT,
        S_PURGE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    append;
        logic    append_flush;
        logic    pop_issue;
        logic    clear;
        logic    set_abort;
        logic    clr_abort;
        logic    purge_start;
        logic    purge_run;
        logic    purge_finish;
        logic    res_load;
        logic    res_pop;
        status_t res_status;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic aborted;
        logic empty;
        logic full;
        logic purge_done;
    } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/message_fifo_with_type_purge.sv */
// message fifo with type purge
// input words on s_axis: tuser carries the command (put, get, flush, abort,
// start, remove), tdata the message type and two arguments. each accepted
// word yields exactly one result word on m_axis: tuser is the status (ok,
// empty, aborted, full), tdata the popped message (zeros unless a get
// succeeded) and the occupancy after the command.
// put, flush, abort, start and the trivial cases load the result register
// on accept, so the result is valid in the next cycle; a successful get goes
// through the registered memory read, then the result register; a remove walks
// the ring one entry per cycle through the single read and write ports.
// throughput: one word per cycle for all commands except get and remove.
// the result register decouples the sides: a new word is taken while the
// previous result is leaving; if m_axis stalls, s_axis_tready drops until
// the result slot frees up, and nothing is lost.
// reset: queue empty and aborted, so put and get report aborted until a
// start command. flush_code sits at apb address 0 and resets to zero.
`timescale 1ns / 1ps
`default_nettype none

module message_fifo_with_type_purge
    import mfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // s_axis_tdata: msg_type, msg_arg_a, msg_arg_b
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [3*WORD_W-1:0]     s_axis_tdata,
    // s_axis_tuser: cmd
    input  logic [CMD_W-1:0]        s_axis_tuser,
    // m_axis_tdata: out_type, out_arg_a, out_arg_b, occupancy, zero pad
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [((3*WORD_W + $clog2(QUEUE_DEPTH+1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // m_axis_tuser: status
    output logic [1:0]              m_axis_tuser,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int M_TDATA_W = ((3 * WORD_W + CNT_W + 7) / 8) * 8;

    logic [WORD_W-1:0] flush_code_reg, flush_code_next;
    logic              cfg_write;

    ctrl_cmd_t         dp_cmd;
    dp_status_t        dp_status;

    logic [WORD_W-1:0] out_type, out_arg_a, out_arg_b;
    logic [CNT_W-1:0]  out_occupancy;

    // apb register file, single register, no wait states
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_FLUSH_CODE) ? flush_code_reg : '0;

    always_comb
    begin
        flush_code_next = flush_code_reg;
        if (cfg_write && (paddr[2] == REG_FLUSH_CODE))
        begin
            flush_code_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_code_reg <= '0;
        end
        else
        begin
            flush_code_reg <= flush_code_next;
        end
    end

    // command sequencing and result handshake
    mfq_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    // ring storage, pointers, purge walker and result register
    mfq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .in_type       (s_axis_tdata[WORD_W-1:0]),
        .in_arg_a      (s_axis_tdata[2*WORD_W-1:WORD_W]),
        .in_arg_b      (s_axis_tdata[3*WORD_W-1:2*WORD_W]),
        .flush_code    (flush_code_reg),
        .out_status    (m_axis_tuser),
        .out_type      (out_type),
        .out_arg_a     (out_arg_a),
        .out_arg_b     (out_arg_b),
        .out_occupancy (out_occupancy)
    );

    // pack result word, type in the lowest bits, zero pad to whole bytes
    assign m_axis_tdata = M_TDATA_W'({out_occupancy, out_arg_b, out_arg_a, out_type});

endmodule

`default_nettype wire

/* hw/rtl/mfq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "message_fifo_with_type_purge_defines.svh"

module mfq_datapath
    import mfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  ctrl_cmd_t                          cmd,
    output dp_status_t                         status,
    input  logic [WORD_W-1:0]                  in_type,
    input  logic [WORD_W-1:0]                  in_arg_a,
    input  logic [WORD_W-1:0]                  in_arg_b,
    input  logic [WORD_W-1:0]                  flush_code,
    output logic [1:0]                         out_status,
    output logic [WORD_W-1:0]                  out_type,
    output logic [WORD_W-1:0]                  out_arg_a,
    output logic [WORD_W-1:0]                  out_arg_b,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   out_occupancy
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = 3 * WORD_W;
    localparam logic [CNT_W:0] DEPTH_EXT = (CNT_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    // ring slot of head plus offset, offset never exceeds the depth
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= DEPTH_EXT)
        begin
            sum = sum - DEPTH_EXT;
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              aborted_reg, aborted_next;
    logic [WORD_W-1:0] purge_type_reg, purge_type_next;
    logic [CNT_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic              pend_reg, pend_next;

    logic [1:0]        out_status_reg;
    logic [WORD_W-1:0] out_type_reg, out_arg_a_reg, out_arg_b_reg;
    logic [CNT_W-1:0]  out_occ_reg;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               purge_issue;
    logic               keep;

    assign purge_issue = cmd.purge_run && (rd_reg != count_reg);
    assign keep = pend_reg && (rdata_reg[WORD_W-1:0] != purge_type_reg);

    assign status.aborted = aborted_reg;
    assign status.empty = (count_reg == '0);
    assign status.full = (count_reg == DEPTH_CNT);
    assign status.purge_done = (rd_reg == count_reg) && !pend_reg;

    // memory port selection
    always_comb
    begin
        rd_en = cmd.pop_issue || purge_issue;
        rd_addr = cmd.pop_issue ? head_reg : wrap_add(head_reg, rd_reg);
        wr_en = cmd.append || keep;
        if (cmd.append)
        begin
            wr_addr = wrap_add(head_reg, count_reg);
            wr_data = cmd.append_flush ? ENTRY_W'(flush_code) : {in_arg_b, in_arg_a, in_type};
        end
        else
        begin
            wr_addr = wrap_add(head_reg, kept_reg);
            wr_data = rdata_reg;
        end
    end

    always_comb
    begin
        head_next = head_reg;
        count_next = count_reg;
        aborted_next = aborted_reg;
        purge_type_next = purge_type_reg;
        rd_next = rd_reg;
        kept_next = kept_reg;
        pend_next = pend_reg;
        if (cmd.append)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop_issue)
        begin
            head_next = wrap_add(head_reg, CNT_W'(1));
            count_next = count_reg - 1'b1;
        end
        if (cmd.clear)
        begin
            count_next = '0;
        end
        if (cmd.set_abort)
        begin
            aborted_next = 1'b1;
        end
        if (cmd.clr_abort)
        begin
            aborted_next = 1'b0;
        end
        if (cmd.purge_start)
        begin
            purge_type_next = in_type;
            rd_next = '0;
            kept_next = '0;
            pend_next = 1'b0;
        end
        if (cmd.purge_run)
        begin
            pend_next = purge_issue;
            if (purge_issue)
            begin
                rd_next = rd_reg + 1'b1;
            end
            if (keep)
            begin
                kept_next = kept_reg + 1'b1;
            end
        end
        if (cmd.purge_finish)
        begin
            count_next = kept_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            count_reg <= '0;
            aborted_reg <= 1'b1;
            rd_reg <= '0;
            kept_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            count_reg <= count_next;
            aborted_reg <= aborted_next;
            rd_reg <= rd_next;
            kept_reg <= kept_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        purge_type_reg <= purge_type_next;
        if (cmd.res_load)
        begin
            out_status_reg <= cmd.res_status;
            out_type_reg <= cmd.res_pop ? rdata_reg[WORD_W-1:0] : '0;
            out_arg_a_reg <= cmd.res_pop ? rdata_reg[2*WORD_W-1:WORD_W] : '0;
            out_arg_b_reg <= cmd.res_pop ? rdata_reg[3*WORD_W-1:2*WORD_W] : '0;
            out_occ_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign out_status = out_status_reg;
    assign out_type = out_type_reg;
    assign out_arg_a = out_arg_a_reg;
    assign out_arg_b = out_arg_b_reg;
    assign out_occupancy = out_occ_reg;

    `MFQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= DEPTH_CNT, "entry count above depth")
    `MFQ_ASSERT(a_kept_behind_read, clk, rst_n, kept_reg <= rd_reg, "purge write ahead of read")
    `MFQ_NEVER(a_no_append_full, clk, rst_n, cmd.append && status.full, "append into full queue")

endmodule

`default_nettype wire

/* hw/rtl/mfq_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "message_fifo_with_type_purge_defines.svh"

module mfq_controller
    import mfq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CMD_W-1:0] in_cmd,
    output logic             out_valid,
    input  logic             out_ready,
    input  dp_status_t       dp_status,
    output ctrl_cmd_t        dp_cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // in idle, a word may enter once the result slot is free or draining this cycle
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        dp_cmd = '0;
        dp_cmd.res_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        CMD_PUT:
                        begin
                            dp_cmd.res_load = 1'b1;
                            if (dp_status.aborted)
                            begin
                                dp_cmd.res_status = ST_ABORTED;
                            end
                            else if (dp_status.full)
                            begin
                                dp_cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                dp_cmd.append = 1'b1;
                            end
                        end
                        CMD_GET:
                        begin
                            if (dp_status.aborted)
                            begin
                                dp_cmd.res_load = 1'b1;
                                dp_cmd.res_status = ST_ABORTED;
                            end
                            else if (dp_status.empty)
                            begin
                                dp_cmd.res_load = 1'b1;
                                dp_cmd.res_status = ST_EMPTY;
                            end
                            else
                            begin
                                dp_cmd.pop_issue = 1'b1;
                                state_next = S_GET_WAIT;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            dp_cmd.clear = 1'b1;
                            dp_cmd.res_load = 1'b1;
                        end
                        CMD_ABORT:
                        begin
                            dp_cmd.set_abort = 1'b1;
                            dp_cmd.res_load = 1'b1;
                        end
                        CMD_START:
                        begin
                            dp_cmd.clr_abort = 1'b1;
                            dp_cmd.res_load = 1'b1;
                            if (dp_status.full)
                            begin
                                dp_cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                dp_cmd.append = 1'b1;
                                dp_cmd.append_flush = 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (dp_status.aborted || dp_status.empty)
                            begin
                                dp_cmd.res_load = 1'b1;
                            end
                            else
                            begin
                                dp_cmd.purge_start = 1'b1;
                                state_next = S_PURGE;
                            end
                        end
                        default:
                        begin
                            dp_cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_GET_WAIT:
            begin
                dp_cmd.res_load = 1'b1;
                dp_cmd.res_pop = 1'b1;
                state_next = S_IDLE;
            end
            S_PURGE:
            begin
                dp_cmd.purge_run = 1'b1;
                if (dp_status.purge_done)
                begin
                    dp_cmd.purge_finish = 1'b1;
                    dp_cmd.res_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (dp_cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MFQ_ASSERT(a_no_result_overwrite, clk, rst_n, dp_cmd.res_load |-> (!out_valid_reg || out_ready), "result overwritten")
    `MFQ_ASSERT(a_get_wait_one, clk, rst_n, (state_reg == S_GET_WAIT) |=> (state_reg == S_IDLE), "get wait too long")
    `MFQ_NEVER(a_pop_legal, clk, rst_n, dp_cmd.pop_issue && (dp_status.aborted || dp_status.empty), "pop of empty or aborted queue")

endmodule

`default_nettype wire
